FILE: src/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types for the contour skyline placer: input and result words and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package csp_pkg;

    // Width of every coordinate and height in the point table and result word.
    localparam int COORD_BITS = 20;

    typedef struct packed {
        logic                  start_new;
        logic [COORD_BITS-1:0] x_left;
        logic [15:0]           block_width;
        logic [15:0]           block_height;
    } csp_in_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] y_bottom;
        logic [COORD_BITS-1:0] packing_width;
        logic [COORD_BITS-1:0] packing_height;
        logic                  overflow;
    } csp_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input word and clear the scan state
        logic root;      // apply a start word
        logic scan;      // examine the current source point
        logic finish;    // publish the result
    } csp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
    } csp_sts_t;

endpackage

FILE: src/contour_skyline_placer.sv
// ----------------------------------------------------------------------------
// contour_skyline_placer
// Places rectangles on a skyline contour and reports each bottom y.
// ----------------------------------------------------------------------------
// Usage: drive a word on cmd_in and raise start while busy is low; the word
// is taken at that edge. A start word (start_new set) rebuilds the contour
// as a single point without raising busy, and its result word is on res_out
// in the very next cycle. Any other word streams the point table from one
// RAM bank into the other, merging the new span as it goes. Each source
// point is first read, the RAM read being registered, and then examined;
// each new point at x_left or at the right end of the span (at most two,
// still taken as a step even when a full table drops it) takes a step of
// its own, and busy then stays high through the end of the scan and the
// publish step. The result word follows in the cycle after busy falls, and
// the next word may be taken in that same cycle. Each result word is on
// res_out for exactly one cycle with res_valid high; the receiver cannot
// stall it. Reset clears the point count and edges; the RAM contents need
// no clearing because only entries below the count are ever read.
// ----------------------------------------------------------------------------
module contour_skyline_placer #(
    parameter int MAX_POINTS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  csp_pkg::csp_in_t  cmd_in,
    output logic              res_valid,
    output csp_pkg::csp_out_t res_out
);
    import csp_pkg::*;

    csp_cmd_t cmd;
    csp_sts_t sts;

    csp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .sts(sts), .start_new(cmd_in.start_new));

    csp_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .din(cmd_in),
        .result(res_out), .done(res_valid));

endmodule

FILE: src/csp_ram.sv
// ----------------------------------------------------------------------------
// csp_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module csp_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/csp_ctrl.sv
// ----------------------------------------------------------------------------
// csp_ctrl
// Sequencer for one placement: load, then for a non-start word scan the contour and finish.
// ----------------------------------------------------------------------------
module csp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output csp_pkg::csp_cmd_t cmd,
    input  csp_pkg::csp_sts_t sts,
    input  logic              start_new
);
    import csp_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (start_new)
                    begin
                        cmd.root = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/csp_dp.sv
// ----------------------------------------------------------------------------
// csp_dp
// Contour datapath. The point table lives in two banks; each non-start
// placement streams the active bank into the other, merging in the new span.
// ----------------------------------------------------------------------------
module csp_dp #(
    parameter int MAX_POINTS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  csp_pkg::csp_cmd_t cmd,
    output csp_pkg::csp_sts_t sts,
    input  csp_pkg::csp_in_t  din,
    output csp_pkg::csp_out_t result,
    output logic              done
);
    import csp_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int PW = 2 * COORD_BITS;
    localparam int EW = COORD_BITS + 1;
    localparam logic [EW-1:0] CMAX = {1'b0, {COORD_BITS{1'b1}}};

    // Scan phases: source index goes through read latency, then each point
    // is emitted or dropped.
    logic              bank_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     rd_reg, ncnt_reg;
    logic              rvld_reg;
    logic [COORD_BITS-1:0] lx_reg, rx_reg, redge_reg, tedge_reg;
    logic [15:0]       h_reg;
    logic              ovf_reg, reach_reg, past_reg;
    logic [COORD_BITS-1:0] lh_reg, mmax_reg, mr_reg;
    logic              have_m_reg, lx_hit_reg, emit_l_reg, rx_hit_reg;

    logic [PW-1:0] rdata0, rdata1, rdata;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [PW-1:0] wdata;

    csp_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_bank0 (
        .clk(clk), .we(we && bank_reg), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata0));
    csp_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_bank1 (
        .clk(clk), .we(we && !bank_reg), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata1));

    assign rdata = bank_reg ? rdata1 : rdata0;
    assign raddr = rd_reg[AW-1:0];

    logic [COORD_BITS-1:0] px, ph;
    assign px = rdata[PW-1:COORD_BITS];
    assign ph = rdata[COORD_BITS-1:0];

    function automatic logic [COORD_BITS-1:0] satf(input logic [EW-1:0] v);
        return (v > CMAX) ? {COORD_BITS{1'b1}} : v[COORD_BITS-1:0];
    endfunction

    // Lifted height y + h for the point at x_left, from the current state.
    logic [COORD_BITS-1:0] y_now, top_now;
    logic [EW-1:0]         top_sum;
    assign y_now   = past_reg ? '0 :
                     ((have_m_reg && mmax_reg > lh_reg) ? mmax_reg : lh_reg);
    assign top_sum = {1'b0, y_now} + EW'(h_reg);
    assign top_now = satf(top_sum);

    // One step of the merge: decide what, if anything, is written.
    logic              w_en, w_drop;
    logic [PW-1:0]     w_pt;
    logic              src_avail, src_done;
    logic              covered;
    logic              rx_pend;
    logic              l_en_c, m_en_c, rx_en_c;
    logic [COORD_BITS-1:0] tail_h;
    logic [CW:0]       fill_c;
    logic              room_c;

    assign src_avail = rvld_reg;
    assign src_done  = (rd_reg >= cnt_reg) && !rvld_reg;
    assign covered   = !past_reg && src_avail && (px > lx_reg) &&
                       (reach_reg || px < rx_reg);
    assign tail_h    = have_m_reg ? mr_reg : lh_reg;
    // A zero-width span ends on its own left point, so no end point is added.
    assign rx_pend   = !reach_reg && !past_reg && !rx_hit_reg && (rx_reg != lx_reg);

    // Points in the new table once every covered point is gone: those
    // written so far plus the source points still to come.
    assign fill_c = {1'b0, ncnt_reg} + {1'b0, cnt_reg - rd_reg};
    assign room_c = fill_c < (CW+1)'(MAX_POINTS);

    logic [EW-1:0] lx_ext, rx_sum;
    assign lx_ext = EW'(din.x_left);
    assign rx_sum = {1'b0, satf(lx_ext)} + EW'(din.block_width);

    always_comb
    begin
        w_en    = 1'b0;
        w_pt    = '0;
        l_en_c  = 1'b0;
        m_en_c  = 1'b0;
        rx_en_c = 1'b0;
        if (cmd.scan && src_avail)
        begin
            if (covered)
            begin
                w_en = 1'b0;
            end
            else if (!past_reg && px == lx_reg)
            begin
                // The point at x_left is written again once its height is known.
                w_en = 1'b0;
            end
            else if (!emit_l_reg && px > lx_reg)
            begin
                // New point at x_left goes in ahead of this source point.
                l_en_c = 1'b1;
                w_en   = 1'b1;
                w_pt   = {lx_reg, top_now};
            end
            else if (rx_pend && px > rx_reg)
            begin
                rx_en_c = 1'b1;
                w_en    = 1'b1;
                w_pt    = {rx_reg, tail_h};
            end
            else
            begin
                m_en_c = 1'b1;
                w_en   = 1'b1;
                w_pt   = rdata;
            end
        end
        else if (cmd.scan && src_done)
        begin
            // Source exhausted: append whatever new points are still due.
            if (!emit_l_reg)
            begin
                l_en_c = 1'b1;
                w_en   = 1'b1;
                w_pt   = {lx_reg, top_now};
            end
            else if (rx_pend)
            begin
                rx_en_c = 1'b1;
                w_en    = 1'b1;
                w_pt    = {rx_reg, tail_h};
            end
        end
        else if (cmd.root)
        begin
            w_en = 1'b1;
            w_pt = {{COORD_BITS{1'b0}}, COORD_BITS'(din.block_height)};
        end
    end

    // An added point is dropped when the table has no room; a point at
    // x_left that already existed is only raised and always fits.
    assign w_drop = ((l_en_c && !lx_hit_reg) || rx_en_c) && !room_c;
    assign we     = w_en && !w_drop;
    assign waddr  = cmd.root ? '0 : ncnt_reg[AW-1:0];
    assign wdata  = w_pt;

    assign sts.scan_done = cmd.scan && src_done && emit_l_reg && !rx_pend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg  <= 1'b0;
            cnt_reg   <= '0;
            redge_reg <= '0;
            tedge_reg <= '0;
            rd_reg    <= '0;
            ncnt_reg  <= '0;
            rvld_reg  <= 1'b0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (cmd.root)
            begin
                bank_reg  <= !bank_reg;
                cnt_reg   <= CW'(1);
                redge_reg <= COORD_BITS'(din.block_width);
                tedge_reg <= COORD_BITS'(din.block_height);
                done      <= 1'b1;
            end
            else if (cmd.load)
            begin
                rd_reg   <= '0;
                ncnt_reg <= '0;
                rvld_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                if (rd_reg < cnt_reg && !rvld_reg)
                begin
                    rvld_reg <= 1'b1;
                end
                else if (rvld_reg && !(l_en_c || rx_en_c))
                begin
                    rd_reg   <= rd_reg + CW'(1);
                    rvld_reg <= 1'b0;
                end
                if (we)
                begin
                    ncnt_reg <= ncnt_reg + CW'(1);
                end
            end
            else if (cmd.finish)
            begin
                bank_reg <= !bank_reg;
                cnt_reg  <= ncnt_reg;
                if (past_reg || reach_reg)
                begin
                    redge_reg <= rx_reg;
                end
                if (top_now > tedge_reg)
                begin
                    tedge_reg <= top_now;
                end
                done <= 1'b1;
            end
        end
    end

    // Payload and scan bookkeeping.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lx_reg     <= satf(lx_ext);
            rx_reg     <= satf(rx_sum);
            h_reg      <= din.block_height;
            ovf_reg    <= rx_sum > CMAX;
            past_reg   <= din.x_left >= redge_reg;
            reach_reg  <= satf(rx_sum) >= redge_reg;
            lh_reg     <= '0;
            mmax_reg   <= '0;
            mr_reg     <= '0;
            have_m_reg <= 1'b0;
            lx_hit_reg <= 1'b0;
            emit_l_reg <= 1'b0;
            rx_hit_reg <= 1'b0;
            if (cmd.root)
            begin
                result.y_bottom       <= '0;
                result.packing_width  <= COORD_BITS'(din.block_width);
                result.packing_height <= COORD_BITS'(din.block_height);
                result.overflow       <= 1'b0;
            end
        end
        else if (cmd.scan)
        begin
            if (src_avail)
            begin
                if (px <= lx_reg)
                begin
                    lh_reg <= ph;
                end
                if (px == lx_reg)
                begin
                    lx_hit_reg <= 1'b1;
                end
                if (covered)
                begin
                    have_m_reg <= 1'b1;
                    mr_reg     <= ph;
                    if (ph > mmax_reg)
                    begin
                        mmax_reg <= ph;
                    end
                end
            end
            // Past the edge an existing point at x_left is simply kept.
            if (l_en_c || (src_avail && past_reg && px == lx_reg))
            begin
                emit_l_reg <= 1'b1;
            end
            if (rx_en_c || (m_en_c && px == rx_reg))
            begin
                rx_hit_reg <= 1'b1;
            end
            if (w_drop)
            begin
                ovf_reg <= 1'b1;
            end
        end
        else if (cmd.finish)
        begin
            result.y_bottom       <= y_now;
            result.packing_width  <= (past_reg || reach_reg) ? rx_reg : redge_reg;
            result.packing_height <= (top_now > tedge_reg) ? top_now : tedge_reg;
            result.overflow       <= ovf_reg || (top_sum > CMAX);
        end
    end

endmodule
